### rtl/srsw_pkg.sv
`default_nettype none

package srsw_pkg;

  // window geometry
  localparam int WINDOW_SLOTS = 16;
  localparam int SLOT_W = $clog2(WINDOW_SLOTS);
  localparam int SEQ_W = 8;
  localparam int TIME_W = 32;

  // opcodes
  localparam logic [1:0] OP_ENQUEUE = 2'd0;
  localparam logic [1:0] OP_ACK     = 2'd1;
  localparam logic [1:0] OP_NAK     = 2'd2;
  localparam logic [1:0] OP_SCAN    = 2'd3;

  // result kinds
  localparam logic [2:0] KIND_ACCEPTED = 3'd0;
  localparam logic [2:0] KIND_FULL     = 3'd1;
  localparam logic [2:0] KIND_RESEND   = 3'd2;
  localparam logic [2:0] KIND_DONE     = 3'd3;
  localparam logic [2:0] KIND_PENDING  = 3'd4;
  localparam logic [2:0] KIND_NONE     = 3'd5;

  localparam logic [TIME_W-1:0] TIMEOUT_RESET = 32'd100000;

  // one window slot as stored in the slot memory
  typedef struct packed {
    logic              acked;
    logic [SEQ_W-1:0]  number;
    logic [TIME_W-1:0] stamp;
  } slot_entry_t;

  // ring successor of a slot index
  function automatic logic [SLOT_W-1:0] ring_next(input logic [SLOT_W-1:0] idx);
    logic [SLOT_W-1:0] res;
    if (idx == SLOT_W'(WINDOW_SLOTS - 1)) begin
      res = '0;
    end else begin
      res = idx + SLOT_W'(1);
    end
    return res;
  endfunction

endpackage

`default_nettype wire

### rtl/srsw_slot_mem.sv
`default_nettype none

module srsw_slot_mem (
  input  wire logic                          clk,
  input  wire logic                          we,
  input  wire logic [srsw_pkg::SLOT_W-1:0]   waddr,
  input  wire srsw_pkg::slot_entry_t         wdata,
  input  wire logic [srsw_pkg::SLOT_W-1:0]   raddr,
  output srsw_pkg::slot_entry_t              rdata
);

  srsw_pkg::slot_entry_t mem [srsw_pkg::WINDOW_SLOTS];

  // single write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

### rtl/selective_repeat_send_window.sv
// Enqueue result is registered and appears in the cycle after the transfer; busy stays low.
// Ack, nak and scan walk the window one slot per cycle through the slot memory
// read port; busy is high until the final result. Scan resends come one per cycle.
// Throughput: one item per cycle for enqueue; ack, nak and scan hold busy until done.
// Reset (rst, synchronous): window empty, sequence 0, retry_timeout 100000; no stall.
`default_nettype none

module selective_repeat_send_window (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                start,
  output      logic                                busy,
  input  wire logic [1:0]                          opcode,
  input  wire logic [srsw_pkg::SEQ_W-1:0]          seq_number,
  input  wire logic [srsw_pkg::TIME_W-1:0]         now_time,
  input  wire logic                                cfg_we,
  input  wire logic [srsw_pkg::TIME_W-1:0]         cfg_wdata,
  output      logic                                result_valid,
  output      logic [2:0]                          kind,
  output      logic [srsw_pkg::SLOT_W-1:0]         slot,
  output      logic [srsw_pkg::SEQ_W-1:0]          frame_number,
  output      logic                                last
);

  typedef enum logic {ST_IDLE, ST_WALK} state_t;

  state_t                          state;
  logic [srsw_pkg::TIME_W-1:0]     retry_timeout;
  logic [srsw_pkg::SLOT_W-1:0]     head_index;
  logic [srsw_pkg::SLOT_W-1:0]     rear_index;
  logic [srsw_pkg::SEQ_W-1:0]      next_sequence;

  // latched item
  logic [1:0]                      op_q;
  logic [srsw_pkg::SEQ_W-1:0]      seq_q;
  logic [srsw_pkg::TIME_W-1:0]     now_q;

  // walk bookkeeping
  logic                            dv;
  logic [srsw_pkg::SLOT_W-1:0]     proc_idx;
  logic [srsw_pkg::SLOT_W-1:0]     nxt;
  logic                            hit_q;
  logic [srsw_pkg::SLOT_W-1:0]     hit_slot_q;
  logic                            front_q;
  logic                            pending_q;

  // memory ports
  logic                            mem_we;
  logic [srsw_pkg::SLOT_W-1:0]     mem_waddr;
  srsw_pkg::slot_entry_t           mem_wdata;
  logic [srsw_pkg::SLOT_W-1:0]     mem_raddr;
  srsw_pkg::slot_entry_t           ent;

  logic                            accept;
  logic                            full;
  logic                            match;
  logic                            mark;
  logic                            acked_new;
  logic                            hit_new;
  logic                            front_new;
  logic                            unacked;
  logic [srsw_pkg::TIME_W-1:0]     elapsed;
  logic                            expired;
  logic                            stop;
  logic                            cont;
  logic                            finish;
  logic                            pending_new;

  srsw_slot_mem u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (ent)
  );

  assign busy   = (state != ST_IDLE);
  assign accept = start && !busy;
  assign full   = (srsw_pkg::ring_next(rear_index) == head_index);

  // per-slot evaluation of the entry read last cycle
  always_comb begin
    match       = (ent.number == seq_q);
    mark        = dv && (op_q == srsw_pkg::OP_ACK) && !hit_q && !ent.acked && match;
    acked_new   = ent.acked | mark;
    hit_new     = hit_q | mark;
    front_new   = front_q && acked_new;
    unacked     = dv && !ent.acked;
    elapsed     = now_q - ent.stamp;
    expired     = unacked && (op_q == srsw_pkg::OP_SCAN) && (elapsed >= retry_timeout);
    pending_new = pending_q | unacked;
    stop        = dv && (((op_q == srsw_pkg::OP_ACK) && hit_new && !front_new) ||
                         ((op_q == srsw_pkg::OP_NAK) && match));
    cont        = dv && !stop && (nxt != rear_index);
    finish      = !dv || stop;
  end

  // read address: head on transfer, next slot while walking
  always_comb begin
    if (state == ST_IDLE) begin
      mem_raddr = head_index;
    end else begin
      mem_raddr = nxt;
    end
  end

  // write port: enqueue fill, ack mark or scan restamp
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = proc_idx;
    mem_wdata = ent;
    if (state == ST_IDLE) begin
      mem_waddr = rear_index;
      mem_wdata = '{acked: 1'b0, number: next_sequence, stamp: now_time};
      mem_we    = accept && (opcode == srsw_pkg::OP_ENQUEUE) && !full;
    end else if (mark) begin
      mem_we          = 1'b1;
      mem_wdata.acked = 1'b1;
    end else if (expired) begin
      mem_we          = 1'b1;
      mem_wdata.stamp = now_q;
    end
  end

  // sequencer, window pointers and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      retry_timeout <= srsw_pkg::TIMEOUT_RESET;
      head_index    <= '0;
      rear_index    <= '0;
      next_sequence <= '0;
      dv            <= 1'b0;
      result_valid  <= 1'b0;
    end else begin
      // result strobe: enqueue answer, scan resend or final walk result
      if (state == ST_IDLE) begin
        result_valid <= accept && (opcode == srsw_pkg::OP_ENQUEUE);
      end else begin
        result_valid <= expired || finish;
      end
      if (cfg_we) begin
        retry_timeout <= cfg_wdata;
      end
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            op_q       <= opcode;
            seq_q      <= seq_number;
            now_q      <= now_time;
            hit_q      <= 1'b0;
            hit_slot_q <= '0;
            front_q    <= 1'b1;
            pending_q  <= 1'b0;
            proc_idx   <= head_index;
            nxt        <= srsw_pkg::ring_next(head_index);
            if (opcode == srsw_pkg::OP_ENQUEUE) begin
              // enqueue updates the window and result registers on the transfer; it needs no walk
              last <= 1'b1;
              if (full) begin
                kind         <= srsw_pkg::KIND_FULL;
                slot         <= '0;
                frame_number <= '0;
              end else begin
                kind          <= srsw_pkg::KIND_ACCEPTED;
                slot          <= rear_index;
                frame_number  <= next_sequence;
                rear_index    <= srsw_pkg::ring_next(rear_index);
                next_sequence <= next_sequence + srsw_pkg::SEQ_W'(1);
              end
            end else begin
              dv    <= (head_index != rear_index);
              state <= ST_WALK;
            end
          end
        end
        ST_WALK: begin
          // walk state update
          if (dv) begin
            front_q   <= front_new;
            pending_q <= pending_new;
            if (mark) begin
              hit_q      <= 1'b1;
              hit_slot_q <= proc_idx;
            end
            if ((op_q == srsw_pkg::OP_ACK) && front_q && acked_new) begin
              head_index <= srsw_pkg::ring_next(proc_idx);
            end
          end
          if (cont) begin
            dv       <= 1'b1;
            proc_idx <= nxt;
            nxt      <= srsw_pkg::ring_next(nxt);
          end else begin
            dv <= 1'b0;
          end
          // results
          if (expired) begin
            kind         <= srsw_pkg::KIND_RESEND;
            slot         <= proc_idx;
            frame_number <= ent.number;
            last         <= 1'b0;
          end else if (finish) begin
            last  <= 1'b1;
            state <= ST_IDLE;
            unique case (op_q)
              srsw_pkg::OP_ACK: begin
                if (hit_new) begin
                  kind         <= srsw_pkg::KIND_ACCEPTED;
                  slot         <= mark ? proc_idx : hit_slot_q;
                  frame_number <= seq_q;
                end else begin
                  kind         <= srsw_pkg::KIND_NONE;
                  slot         <= '0;
                  frame_number <= '0;
                end
              end
              srsw_pkg::OP_NAK: begin
                if (dv && match) begin
                  kind         <= srsw_pkg::KIND_RESEND;
                  slot         <= proc_idx;
                  frame_number <= seq_q;
                end else begin
                  kind         <= srsw_pkg::KIND_NONE;
                  slot         <= '0;
                  frame_number <= '0;
                end
              end
              srsw_pkg::OP_SCAN: begin
                kind         <= pending_new ? srsw_pkg::KIND_PENDING : srsw_pkg::KIND_DONE;
                slot         <= '0;
                frame_number <= '0;
              end
              default: begin
                kind         <= srsw_pkg::KIND_NONE;
                slot         <= '0;
                frame_number <= '0;
              end
            endcase
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTH
  // enqueue answers on the very next cycle with a final result
  a_enq_answer: assert property (@(posedge clk) disable iff (rst)
    accept && (opcode == srsw_pkg::OP_ENQUEUE) |=> result_valid && last)
    else $error("enqueue transfer without final result");

  // the walk never reaches the rear slot
  a_walk_in_window: assert property (@(posedge clk) disable iff (rst)
    (state == ST_WALK) && dv |-> proc_idx != rear_index)
    else $error("walk processed a slot outside the window");

  // write-back never hits the slot being read in the same cycle
  a_no_rw_overlap: assert property (@(posedge clk) disable iff (rst)
    (state == ST_WALK) && mem_we |-> mem_waddr != mem_raddr)
    else $error("slot write-back collides with read");

  // a non-final result means more results follow
  a_more_follow: assert property (@(posedge clk) disable iff (rst)
    result_valid && !last |-> busy)
    else $error("non-final result while idle");
`endif

endmodule

`default_nettype wire
